### rtl/pcm_peak_track_gain_saturate_defines.svh
// ----------------------------------------------------------------------------
// pcm_peak_track_gain_saturate_defines.svh
// Assertion macros shared by the PCM gain and peak tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PCM_PEAK_TRACK_GAIN_SATURATE_DEFINES_SVH
`define PCM_PEAK_TRACK_GAIN_SATURATE_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define PPTG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its antecedent.
`define PPTG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequence holds in the cycle after its antecedent.
`define PPTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pptg_pkg.sv
// ----------------------------------------------------------------------------
// pptg_pkg
// Types and constants for the PCM gain, saturation and peak tracker.
// ----------------------------------------------------------------------------
package pptg_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int BYTE_W         = 8;
    localparam int GAIN_W         = 31;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int PROD_W         = SAMPLE_W + GAIN_W;
    localparam int RMAG_W         = PROD_W - GAIN_FRAC_BITS;

    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [GAIN_W-1:0]   GAIN_RESET = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

    // Saturation limits on the magnitude, per sample width
    localparam logic [SAMPLE_W-1:0] POS_MAX_16 = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SAMPLE_W-1:0] NEG_MAX_16 = SAMPLE_W'(1 << (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0] POS_MAX_8  = SAMPLE_W'((1 << (BYTE_W - 1)) - 1);
    localparam logic [SAMPLE_W-1:0] NEG_MAX_8  = SAMPLE_W'(1 << (BYTE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [SAMPLE_W-1:0] mag_t;
    typedef logic        [GAIN_W-1:0]   gain_t;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-3:0] {
        REG_GAIN         = 1'b0,
        REG_SAMPLE_WIDTH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        gain_t gain;
        logic  width8;
    } cfg_t;

endpackage

### rtl/pptg_if.sv
// ----------------------------------------------------------------------------
// pptg_if
// Valid/ready channels for input samples and scaled results.
// ----------------------------------------------------------------------------
interface pptg_sample_if;
    import pptg_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    clear_peak;

    modport source (output valid, output sample, output clear_peak, input ready);
    modport sink   (input valid, input sample, input clear_peak, output ready);
endinterface

interface pptg_result_if;
    import pptg_pkg::*;

    logic    valid;
    logic    ready;
    sample_t scaled_sample;
    mag_t    peak;

    modport source (output valid, output scaled_sample, output peak, input ready);
    modport sink   (input valid, input scaled_sample, input peak, output ready);
endinterface

### rtl/pptg_cfg_regs.sv
// ----------------------------------------------------------------------------
// pptg_cfg_regs
// APB register file holding the gain and the sample width select.
// ----------------------------------------------------------------------------
module pptg_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pptg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pptg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pptg_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    output pptg_pkg::cfg_t                   cfg
);
    import pptg_pkg::*;

    reg_idx_t idx;
    logic     wr_en;
    gain_t    gain_reg;
    logic     width8_reg;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            width8_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN:         gain_reg   <= pwdata[GAIN_W-1:0];
                REG_SAMPLE_WIDTH: width8_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN:         prdata = APB_DATA_W'(gain_reg);
            REG_SAMPLE_WIDTH: prdata = APB_DATA_W'(width8_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.gain   = gain_reg;
    assign cfg.width8 = width8_reg;

endmodule

### rtl/pptg_datapath.sv
// ----------------------------------------------------------------------------
// pptg_datapath
// Input register, gain multiply with rounding and saturation, peak update
// and result register.
// ----------------------------------------------------------------------------
`include "pcm_peak_track_gain_saturate_defines.svh"

module pptg_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  pptg_pkg::cfg_t cfg,
    pptg_sample_if.sink    samples,
    pptg_result_if.source  results
);
    import pptg_pkg::*;

    // Input stage
    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    s1_clear_reg;

    // Result stage
    logic    out_valid_reg;
    sample_t out_sample_reg;
    mag_t    out_peak_reg;

    // Running peak
    mag_t    peak_mag_reg;
    mag_t    peak_mag_next;

    logic    out_load;
    logic    s1_advance;

    sample_t picked;
    logic    neg;
    mag_t    mag;
    mag_t    peak_base;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rounded;
    logic [RMAG_W-1:0] rmag;
    mag_t    limit;
    mag_t    sat_mag;
    sample_t result;

    assign out_load      = !out_valid_reg || results.ready;
    assign s1_advance    = s1_valid_reg && out_load;
    assign samples.ready = !s1_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.sample;
            s1_clear_reg  <= samples.clear_peak;
        end
    end

    // Pick the sample at the selected width and take its magnitude
    always_comb
    begin
        if (cfg.width8)
            picked = SAMPLE_W'(signed'(s1_sample_reg[BYTE_W-1:0]));
        else
            picked = s1_sample_reg;
        neg = picked[SAMPLE_W-1];
        mag = neg ? mag_t'(-picked) : mag_t'(picked);
    end

    // Restart from zero on a clear, then keep the larger magnitude
    always_comb
    begin
        peak_base     = s1_clear_reg ? '0 : peak_mag_reg;
        peak_mag_next = (mag > peak_base) ? mag : peak_base;
    end

    // Scale, round half away from zero on the magnitude, saturate, restore sign
    always_comb
    begin
        prod    = PROD_W'(mag) * PROD_W'(cfg.gain);
        rounded = prod + ROUND_HALF;
        rmag    = rounded[PROD_W-1:GAIN_FRAC_BITS];
        if (cfg.width8)
            limit = neg ? NEG_MAX_8 : POS_MAX_8;
        else
            limit = neg ? NEG_MAX_16 : POS_MAX_16;
        sat_mag = (rmag > RMAG_W'(limit)) ? limit : rmag[SAMPLE_W-1:0];
        result  = neg ? sample_t'(-sat_mag) : sample_t'(sat_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_mag_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
                peak_mag_reg <= peak_mag_next;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sample_reg <= result;
            out_peak_reg   <= peak_mag_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.scaled_sample = out_sample_reg;
    assign results.peak          = out_peak_reg;

    `PPTG_ASSERT_SAME(a_peak_bound, out_valid_reg, out_peak_reg <= NEG_MAX_16, "peak above full scale")
    `PPTG_ASSERT_SAME(a_byte_range, out_valid_reg && cfg.width8, (out_sample_reg <= sample_t'(POS_MAX_8)) && (out_sample_reg >= -sample_t'(NEG_MAX_8)), "8-bit result out of range")
    `PPTG_ASSERT_NEXT(a_peak_grows, s1_advance && !s1_clear_reg, peak_mag_reg >= $past(peak_mag_reg), "peak fell without a clear")
    `PPTG_ASSERT_NEXT(a_result_loads, s1_advance, out_valid_reg, "advanced item not presented")

endmodule

### rtl/pcm_peak_track_gain_saturate.sv
// ----------------------------------------------------------------------------
// pcm_peak_track_gain_saturate: PCM gain with rounding, saturation and peak.
// Accepted samples pass the input register, then the result register.
// Throughput one sample per cycle unless results stall; multiply path sets it.
// Reset (rst_n low, async) empties both stages, zeroes the peak, gain = 1.0.
// ----------------------------------------------------------------------------
module pcm_peak_track_gain_saturate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pptg_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pptg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pptg_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    pptg_sample_if.sink                      samples,
    pptg_result_if.source                    results
);
    import pptg_pkg::*;

    // Configuration as held in the register file; the gain is Q15.16 and
    // the width select picks 16-bit or 8-bit samples. The user must write both
    // only while no transaction is in flight; the block does not enforce this.
    cfg_t cfg;

    // APB register file: gain at byte address 0, width select at 4
    pptg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sample path: hold each accepted transaction in the input register,
    // scale, round and saturate it, update the running peak, and advance the
    // result into the output register, which parts the two channels: while a
    // result waits, a new sample is still taken into an empty input register.
    pptg_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .results (results)
    );

endmodule
